// ===== rtl/dkbh_pkg.sv =====
`default_nettype none

package dkbh_pkg;

	localparam int BUCKET_BITS = 10;
	localparam int COUNT_BITS  = 32;
	localparam int KEY_BITS    = 60;
	localparam int KLEN_BITS   = 5;
	localparam int SHIFT_BITS  = KLEN_BITS + 1;
	localparam int OUT_BITS    = 32;
	localparam int MODE_BITS   = 2;
	localparam int TABLE_DEPTH = 1 << BUCKET_BITS;
	localparam logic [KLEN_BITS-1:0] KLEN_RESET = KLEN_BITS'(15);

	typedef enum logic [MODE_BITS-1:0] {
		MODE_PUSH   = 2'd0,
		MODE_FINISH = 2'd1,
		MODE_READ   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_RD,
		S_CLR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic write_back;
		logic clr_start;
		logic clr_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic use_mem;
		logic count_pend;
		logic is_clear;
		logic clr_last;
		logic out_free;
	} status_t;

	// max(0, 2*klen - BUCKET_BITS)
	function automatic logic [SHIFT_BITS-1:0] shift_amt(input logic [KLEN_BITS-1:0] klen);
		logic [SHIFT_BITS-1:0] twice;
		twice = {klen, 1'b0};
		if (twice > SHIFT_BITS'(BUCKET_BITS))
			return twice - SHIFT_BITS'(BUCKET_BITS);
		else
			return '0;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dkbh_if.sv =====
`default_nettype none

interface dkbh_req_if;
	logic                              valid;
	logic                              ready;
	logic [dkbh_pkg::MODE_BITS-1:0]    mode;
	logic [dkbh_pkg::KEY_BITS-1:0]     key;
	logic [dkbh_pkg::BUCKET_BITS-1:0]  bucket_index;

	modport source (output valid, mode, key, bucket_index, input ready);
	modport sink   (input valid, mode, key, bucket_index, output ready);
endinterface

interface dkbh_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [dkbh_pkg::OUT_BITS-1:0]  bucket_count;
	logic [dkbh_pkg::OUT_BITS-1:0]  total_keys;
	logic                           order_error;

	modport source (output valid, bucket_count, total_keys, order_error, input ready);
	modport sink   (input valid, bucket_count, total_keys, order_error, output ready);
endinterface

interface dkbh_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [dkbh_pkg::KLEN_BITS-1:0]  kmer_len;

	modport source (output valid, kmer_len, input ready);
	modport sink   (input valid, kmer_len, output ready);
endinterface

`default_nettype wire

// ===== rtl/dkbh_ctrl.sv =====
`default_nettype none

module dkbh_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire dkbh_pkg::status_t sts,
	output dkbh_pkg::cmd_t         cmd
);

	dkbh_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dkbh_pkg::S_INIT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dkbh_pkg::S_INIT: begin
				if (sts.clr_last)
					state_d = dkbh_pkg::S_IDLE;
			end
			dkbh_pkg::S_IDLE: begin
				if (in_valid)
					state_d = dkbh_pkg::S_EXEC;
			end
			dkbh_pkg::S_EXEC: begin
				if (sts.is_clear)
					state_d = dkbh_pkg::S_CLR;
				else if (sts.use_mem)
					state_d = dkbh_pkg::S_RD;
				else
					state_d = dkbh_pkg::S_RESP;
			end
			dkbh_pkg::S_RD: begin
				state_d = dkbh_pkg::S_RESP;
			end
			dkbh_pkg::S_CLR: begin
				if (sts.clr_last)
					state_d = dkbh_pkg::S_RESP;
			end
			dkbh_pkg::S_RESP: begin
				if (sts.out_free)
					state_d = dkbh_pkg::S_IDLE;
			end
			default: state_d = dkbh_pkg::S_INIT;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			dkbh_pkg::S_INIT: cmd.clr_step = 1'b1;
			dkbh_pkg::S_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			dkbh_pkg::S_EXEC: begin
				cmd.exec      = 1'b1;
				cmd.clr_start = sts.is_clear;
			end
			dkbh_pkg::S_RD:   cmd.write_back = sts.count_pend;
			dkbh_pkg::S_CLR:  cmd.clr_step = 1'b1;
			dkbh_pkg::S_RESP: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	// data read in S_RD always comes from the address issued in S_EXEC
	a_rd_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dkbh_pkg::S_RD |-> $past(state_q) == dkbh_pkg::S_EXEC)
		else $error("read state not preceded by execute");

	// a clear sweep runs to its last entry without leaving early
	a_clr_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dkbh_pkg::S_CLR && !sts.clr_last |=> state_q == dkbh_pkg::S_CLR)
		else $error("clear sweep cut short");

endmodule

`default_nettype wire

// ===== rtl/dkbh_dp.sv =====
`default_nettype none

module dkbh_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire dkbh_pkg::cmd_t                   cmd,
	output dkbh_pkg::status_t                     sts,
	input  wire logic [dkbh_pkg::MODE_BITS-1:0]   in_mode,
	input  wire logic [dkbh_pkg::KEY_BITS-1:0]    in_key,
	input  wire logic [dkbh_pkg::BUCKET_BITS-1:0] in_idx,
	input  wire logic                             cfg_we,
	input  wire logic [dkbh_pkg::KLEN_BITS-1:0]   cfg_data,
	input  wire logic                             out_ready,
	output logic                                  out_valid,
	output logic [dkbh_pkg::OUT_BITS-1:0]         out_bucket_count,
	output logic [dkbh_pkg::OUT_BITS-1:0]         out_total,
	output logic                                  out_error
);

	logic [dkbh_pkg::COUNT_BITS-1:0] mem [dkbh_pkg::TABLE_DEPTH];

	logic [dkbh_pkg::KLEN_BITS-1:0]   kmer_len_q;
	dkbh_pkg::mode_t                  mode_q;
	logic [dkbh_pkg::KEY_BITS-1:0]    key_q;
	logic [dkbh_pkg::BUCKET_BITS-1:0] idx_q;
	logic [dkbh_pkg::KEY_BITS-1:0]    prev_key_q;
	logic                             prev_valid_q;
	logic [dkbh_pkg::COUNT_BITS-1:0]  total_q;
	logic                             error_q;
	logic                             count_q;
	logic [dkbh_pkg::BUCKET_BITS-1:0] addr_q;
	logic [dkbh_pkg::COUNT_BITS-1:0]  rd_data_q;
	logic [dkbh_pkg::BUCKET_BITS-1:0] clr_addr_q;
	logic                             out_valid_q;
	logic [dkbh_pkg::OUT_BITS-1:0]    out_count_q;
	logic [dkbh_pkg::OUT_BITS-1:0]    out_total_q;
	logic                             out_error_q;

	logic                             key_up;
	logic                             count_ev;
	logic [dkbh_pkg::BUCKET_BITS-1:0] bucket;
	logic [dkbh_pkg::BUCKET_BITS-1:0] rd_addr;
	logic [dkbh_pkg::COUNT_BITS-1:0]  bump;
	logic [dkbh_pkg::BUCKET_BITS-1:0] wr_addr;
	logic [dkbh_pkg::COUNT_BITS-1:0]  wr_data;
	logic                             wr_en;

	// bucket of the run being closed
	assign bucket  = dkbh_pkg::BUCKET_BITS'(prev_key_q >> dkbh_pkg::shift_amt(kmer_len_q));
	assign key_up  = key_q > prev_key_q;
	assign count_ev = prev_valid_q &&
		((mode_q == dkbh_pkg::MODE_PUSH && key_up) || mode_q == dkbh_pkg::MODE_FINISH);
	assign rd_addr = (mode_q == dkbh_pkg::MODE_READ) ? idx_q : bucket;
	assign bump    = (rd_data_q == '1) ? rd_data_q : rd_data_q + 1'b1;

	assign wr_en   = cmd.write_back || cmd.clr_step;
	assign wr_addr = cmd.write_back ? addr_q : clr_addr_q;
	assign wr_data = cmd.write_back ? bump : '0;

	always_comb begin
		sts            = '0;
		sts.use_mem    = count_ev || mode_q == dkbh_pkg::MODE_READ;
		sts.count_pend = count_q;
		sts.is_clear   = mode_q == dkbh_pkg::MODE_CLEAR;
		sts.clr_last   = clr_addr_q == '1;
		sts.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec)
			rd_data_q <= mem[rd_addr];
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// item payload, memory address and response fields need no reset
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q <= dkbh_pkg::mode_t'(in_mode);
			key_q  <= in_key;
			idx_q  <= in_idx;
		end
		if (cmd.exec)
			addr_q <= rd_addr;
		if (cmd.out_load) begin
			out_count_q <= (mode_q == dkbh_pkg::MODE_READ) ?
				dkbh_pkg::OUT_BITS'(rd_data_q) : '0;
			out_total_q <= dkbh_pkg::OUT_BITS'(total_q);
			out_error_q <= error_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q   <= dkbh_pkg::KLEN_RESET;
			prev_key_q   <= '0;
			prev_valid_q <= 1'b0;
			total_q      <= '0;
			error_q      <= 1'b0;
			count_q      <= 1'b0;
			clr_addr_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we)
				kmer_len_q <= cfg_data;

			if (cmd.clr_start) begin
				prev_key_q   <= '0;
				prev_valid_q <= 1'b0;
				total_q      <= '0;
				error_q      <= 1'b0;
				clr_addr_q   <= '0;
				count_q      <= 1'b0;
			end else if (cmd.exec) begin
				count_q <= count_ev;
				if (mode_q == dkbh_pkg::MODE_PUSH) begin
					if (!prev_valid_q) begin
						prev_key_q   <= key_q;
						prev_valid_q <= 1'b1;
					end else if (key_up) begin
						prev_key_q <= key_q;
					end else if (key_q != prev_key_q) begin
						error_q <= 1'b1;
					end
				end else if (mode_q == dkbh_pkg::MODE_FINISH) begin
					prev_valid_q <= 1'b0;
				end
			end else begin
				if (cmd.write_back && total_q != '1)
					total_q <= total_q + 1'b1;
				if (cmd.clr_step)
					clr_addr_q <= clr_addr_q + 1'b1;
			end

			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_bucket_count = out_count_q;
	assign out_total        = out_total_q;
	assign out_error        = out_error_q;

	// the distinct total only drops through a clear
	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.clr_start |=> total_q >= $past(total_q))
		else $error("distinct total decreased without a clear");

	// only a read request returns a nonzero bucket count
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && mode_q != dkbh_pkg::MODE_READ |=> out_count_q == '0)
		else $error("bucket count returned for a non-read request");

endmodule

`default_nettype wire

// ===== rtl/distinct_key_bucket_histogram.sv =====
// Distinct-key bucket histogram. Send ascending k-mer keys with mode push;
// each run of equal keys is counted once, into bucket
// (key >> max(0, 2*kmer_len - 10)) & 0x3FF, when a larger key or a finish
// request closes it. A key below its predecessor sets the sticky order_error
// flag and is dropped. Mode read returns one bucket's count, mode clear zeroes
// the whole table, the total, the open run and the error flag. Every request
// returns exactly one response carrying total_keys and order_error after the
// request; bucket_count is nonzero only for a read. Counters saturate.
// Requests are handled one at a time through a single-port 1024 x 32 count
// memory with a registered read: a push that opens or extends a run, or a
// finish with no open run, goes through accept, execute and respond; one that
// closes a run, or a read, adds a read state, in which a closing run writes
// back its incremented count, and a clear sweeps the memory one entry per
// cycle. After reset the same sweep runs over the whole table before the first
// request is taken; kmer_len (reset 15) may be written at any time the block
// is idle, the sweep included. The response sits in an output register, so the
// next request is taken while the previous response waits.
`default_nettype none

module distinct_key_bucket_histogram (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dkbh_req_if.sink   req,
	dkbh_rsp_if.source rsp,
	dkbh_cfg_if.sink   cfg
);

	dkbh_pkg::cmd_t    cmd;
	dkbh_pkg::status_t sts;
	logic              in_ready;

	// the configuration register is always ready, so a write is never stalled
	assign cfg.ready = 1'b1;
	assign req.ready = in_ready;

	// sequence each request: accept, execute, then a memory read, write-back or clear sweep where needed, respond
	dkbh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold the run state, the count memory, the total and the response register
	dkbh_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_mode          (req.mode),
		.in_key           (req.key),
		.in_idx           (req.bucket_index),
		.cfg_we           (cfg.valid),
		.cfg_data         (cfg.kmer_len),
		.out_ready        (rsp.ready),
		.out_valid        (rsp.valid),
		.out_bucket_count (rsp.bucket_count),
		.out_total        (rsp.total_keys),
		.out_error        (rsp.order_error)
	);

endmodule

`default_nettype wire
